[rtl/core/gcode_line_parser_defines.svh]
// assertion macros for the g-code line parser
// no dependencies; included by the files that carry assertions
`ifndef GCODE_LINE_PARSER_DEFINES_SVH
`define GCODE_LINE_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define GLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glp assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glp assertion failed");

`endif

[rtl/core/glp_pkg.sv]
// shared types and constants of the g-code line parser
// no dependencies; used by glp_num_conv and gcode_line_parser
package glp_pkg;

  // result command codes
  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_INIT  = 3'd1,
    CMD_SERVO = 3'd2,
    CMD_MOVE  = 3'd3,
    CMD_HOME  = 3'd4
  } cmd_e;

  // keywords, first character in lowest byte
  localparam logic [23:0] KW_M10 = 24'h30314D;
  localparam logic [23:0] KW_M1  = 24'h00314D;
  localparam logic [23:0] KW_G1  = 24'h003147;
  localparam logic [23:0] KW_G28 = 24'h383247;

  // characters
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_VT    = 8'd11;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SP    = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // magnitude clamp and positive limit
  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  localparam int unsigned FRAC_W  = 3;
  localparam int unsigned SCALE_W = 14;

  // control from the tokenizer to one number converter
  typedef struct packed {
    logic step;
    logic clear;
  } num_ctrl_t;

  // scale factor for the missing fraction digits
  function automatic logic [SCALE_W-1:0] pow10(input logic [FRAC_W-1:0] k);
    logic [SCALE_W-1:0] r;
    unique case (k)
      3'd0:    r = 14'd1;
      3'd1:    r = 14'd10;
      3'd2:    r = 14'd100;
      3'd3:    r = 14'd1000;
      default: r = 14'd10000;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/gcode_line_parser.sv]
// a line-end word gives its result word in the cycle after it is accepted
// one input word per cycle, but a line-end word stalls while a result waits on a stalled
// receiver; character words give no result; each character takes a multiply-by-ten accumulate,
// and the scaled, clamped coordinates are taken into the held point at the line end
// reset (rst_ni low, asynchronous) clears line state, held point and pen at once
// top level of the g-code line parser; depends on glp_pkg, glp_num_conv and the defines header
`include "gcode_line_parser_defines.svh"

module gcode_line_parser #(
  parameter int unsigned TOKEN_CHARS     = 8,
  parameter int unsigned FRACTION_DIGITS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_byte_i,
  input  logic               line_end_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         command_code_o,
  output logic signed [31:0] x_thousandths_o,
  output logic signed [31:0] y_thousandths_o,
  output logic [63:0]        pen_chars_o,
  output logic [3:0]         pen_length_o
);

  localparam int unsigned PEN_W = 8 * TOKEN_CHARS;
  localparam int unsigned POS_W = $clog2(TOKEN_CHARS);

  // handshake
  logic in_acc, out_acc;

  // line state
  logic [2:0]       tok_q, tok_d;
  logic [3:0]       pos_q, pos_d;
  logic [23:0]      kw_q, kw_d;
  logic             kw_long_q, kw_long_d;
  logic [PEN_W-1:0] sec_q, sec_d;
  logic [3:0]       sec_len_q, sec_len_d;

  // held values and result
  logic signed [31:0] held_x_q, held_x_d, held_y_q, held_y_d;
  logic [PEN_W-1:0]   held_pen_q, held_pen_d;
  logic [3:0]         held_len_q, held_len_d;
  glp_pkg::cmd_e      code_q, cmd_d;
  logic               out_valid_q, out_valid_d;

  glp_pkg::num_ctrl_t x_ctrl, y_ctrl;
  logic signed [31:0] x_val, y_val;
  logic               is_sep, is_char;

  // the output word is read straight from the held registers: they only change
  // on a line end, and a line end is stalled while a result waits
  assign out_acc    = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i && line_end_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_sep  = (char_byte_i == glp_pkg::CHAR_NL) || (char_byte_i == glp_pkg::CHAR_SP);
  assign is_char = !line_end_i && (char_byte_i != glp_pkg::CHAR_NUL) && !is_sep;

  // exact keyword match, overlong keywords never match
  always_comb begin
    cmd_d = glp_pkg::CMD_CLEAR;
    if (!kw_long_q) begin
      priority if (kw_q == glp_pkg::KW_M10) cmd_d = glp_pkg::CMD_INIT;
      else if (kw_q == glp_pkg::KW_M1)      cmd_d = glp_pkg::CMD_SERVO;
      else if (kw_q == glp_pkg::KW_G1)      cmd_d = glp_pkg::CMD_MOVE;
      else if (kw_q == glp_pkg::KW_G28)     cmd_d = glp_pkg::CMD_HOME;
      else                                  cmd_d = glp_pkg::CMD_CLEAR;
    end
  end

  // coordinate converters see tokens two and three, axis letter skipped
  always_comb begin
    x_ctrl       = '0;
    y_ctrl       = '0;
    x_ctrl.clear = in_acc && line_end_i;
    y_ctrl.clear = in_acc && line_end_i;
    x_ctrl.step  = in_acc && is_char && (tok_q == 3'd1) && (pos_q != 4'd0);
    y_ctrl.step  = in_acc && is_char && (tok_q == 3'd2) && (pos_q != 4'd0);
  end

  glp_num_conv #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_x_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (x_ctrl),
    .char_i (char_byte_i),
    .value_o(x_val)
  );

  glp_num_conv #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_y_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (y_ctrl),
    .char_i (char_byte_i),
    .value_o(y_val)
  );

  // tokenizer and held-value update
  always_comb begin
    tok_d       = tok_q;
    pos_d       = pos_q;
    kw_d        = kw_q;
    kw_long_d   = kw_long_q;
    sec_d       = sec_q;
    sec_len_d   = sec_len_q;
    held_x_d    = held_x_q;
    held_y_d    = held_y_q;
    held_pen_d  = held_pen_q;
    held_len_d  = held_len_q;
    out_valid_d = out_acc ? 1'b0 : out_valid_q;

    if (in_acc) begin
      if (line_end_i) begin
        // commit what the command updates, then start a fresh line
        unique case (cmd_d)
          glp_pkg::CMD_SERVO: begin
            held_pen_d = sec_q;
            held_len_d = sec_len_q;
          end
          glp_pkg::CMD_MOVE: begin
            held_x_d = x_val;
            held_y_d = y_val;
          end
          default: ;
        endcase
        out_valid_d = 1'b1;
        tok_d       = '0;
        pos_d       = '0;
        kw_d        = '0;
        kw_long_d   = 1'b0;
        sec_d       = '0;
        sec_len_d   = '0;
      end else if (is_sep) begin
        // separator closes a token, empty tokens count too
        if (tok_q != 3'd7) tok_d = tok_q + 3'd1;
        pos_d = '0;
      end else if (is_char) begin
        if (tok_q == 3'd0) begin
          if (pos_q < 4'd3) begin
            kw_d[{pos_q[1:0], 3'b000} +: 8] = char_byte_i;
          end else begin
            kw_long_d = 1'b1;
          end
        end else if (tok_q == 3'd1) begin
          // pen text keeps the first characters only
          if (pos_q < 4'(TOKEN_CHARS)) begin
            sec_d[8 * pos_q[POS_W-1:0] +: 8] = char_byte_i;
            sec_len_d = pos_q + 4'd1;
          end
        end
        if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= '0;
      pos_q       <= '0;
      kw_q        <= '0;
      kw_long_q   <= 1'b0;
      sec_q       <= '0;
      sec_len_q   <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_pen_q  <= '0;
      held_len_q  <= '0;
      code_q      <= glp_pkg::CMD_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      tok_q       <= tok_d;
      pos_q       <= pos_d;
      kw_q        <= kw_d;
      kw_long_q   <= kw_long_d;
      sec_q       <= sec_d;
      sec_len_q   <= sec_len_d;
      held_x_q    <= held_x_d;
      held_y_q    <= held_y_d;
      held_pen_q  <= held_pen_d;
      held_len_q  <= held_len_d;
      out_valid_q <= out_valid_d;
      if (in_acc && line_end_i) code_q <= cmd_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_code_o  = code_q;
  assign x_thousandths_o = held_x_q;
  assign y_thousandths_o = held_y_q;
  assign pen_chars_o     = 64'(held_pen_q);
  assign pen_length_o    = held_len_q;

  // a line end always yields a result in the next cycle
  `GLP_ASSERT_NEXT(a_line_end_result, clk_i, rst_ni, in_acc && line_end_i, out_valid_o)
  // a line end leaves the tokenizer at the start of a line
  `GLP_ASSERT_NEXT(a_line_restart, clk_i, rst_ni, in_acc && line_end_i,
                   (tok_q == 3'd0) && (pos_q == 4'd0) && !kw_long_q)
  // only a move command touches the held point
  `GLP_ASSERT_NEXT(a_point_held, clk_i, rst_ni,
                   in_acc && line_end_i && (cmd_d != glp_pkg::CMD_MOVE),
                   $stable(held_x_q) && $stable(held_y_q))
  // pen length never exceeds the kept characters
  `GLP_ASSERT_NOW(a_pen_len, clk_i, rst_ni, 1'b1, held_len_q <= 4'(TOKEN_CHARS))

endmodule

[rtl/core/glp_num_conv.sv]
// decimal coordinate converter: accumulates one character per cycle,
// gives the scaled, saturated value in thousandths; depends on glp_pkg
module glp_num_conv #(
  parameter int unsigned FRACTION_DIGITS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  glp_pkg::num_ctrl_t  ctrl_i,
  input  logic [7:0]          char_i,
  output logic signed [31:0]  value_o
);

  typedef struct packed {
    logic [glp_pkg::FRAC_W-1:0] frac;
    logic                       nosgn;
    logic                       stop;
    logic                       point;
    logic                       neg;
  } num_flags_t;

  logic [31:0] acc_q, acc_d;
  num_flags_t  fl_q, fl_d;

  logic        is_digit, is_ws, is_sign, take;
  logic [3:0]  digit;
  logic [35:0] acc_x10;
  logic [glp_pkg::FRAC_W-1:0]  frac_k;
  logic [glp_pkg::SCALE_W-1:0] scale;
  logic [45:0] scaled;
  logic [31:0] mag;

  assign is_digit = (char_i >= glp_pkg::CHAR_ZERO) && (char_i <= glp_pkg::CHAR_NINE);
  assign is_ws    = (char_i == glp_pkg::CHAR_TAB) || (char_i == glp_pkg::CHAR_VT) ||
                    (char_i == glp_pkg::CHAR_FF)  || (char_i == glp_pkg::CHAR_CR);
  assign is_sign  = (char_i == glp_pkg::CHAR_PLUS) || (char_i == glp_pkg::CHAR_MINUS);
  assign digit    = 4'(char_i - glp_pkg::CHAR_ZERO);
  // acc * 10 + digit as shift-add
  assign acc_x10  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 36'(digit);

  always_comb begin
    acc_d = acc_q;
    fl_d  = fl_q;
    take  = 1'b1;
    if (ctrl_i.clear) begin
      acc_d = '0;
      fl_d  = '0;
    end else if (ctrl_i.step && !fl_q.stop) begin
      priority if (!fl_q.nosgn && is_ws) begin
        // leading whitespace skipped
      end else if (!fl_q.nosgn && is_sign) begin
        fl_d.nosgn = 1'b1;
        if (char_i == glp_pkg::CHAR_MINUS) fl_d.neg = 1'b1;
      end else if (is_digit) begin
        fl_d.nosgn = 1'b1;
        if (fl_q.point) begin
          if (fl_q.frac < glp_pkg::FRAC_W'(FRACTION_DIGITS)) begin
            fl_d.frac = fl_q.frac + 1'b1;
          end else begin
            take = 1'b0;
          end
        end
        // acc never exceeds the cap, so bit 31 means it sits there
        if (take && !acc_q[31]) begin
          acc_d = (acc_x10 > 36'(glp_pkg::MAG_CAP)) ? glp_pkg::MAG_CAP : acc_x10[31:0];
        end
      end else if (char_i == glp_pkg::CHAR_POINT && !fl_q.point) begin
        fl_d.point = 1'b1;
        fl_d.nosgn = 1'b1;
      end else begin
        fl_d.stop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      fl_q  <= '0;
    end else begin
      acc_q <= acc_d;
      fl_q  <= fl_d;
    end
  end

  // scale up for the fraction digits not given
  assign frac_k = glp_pkg::FRAC_W'(FRACTION_DIGITS) - fl_q.frac;
  assign scale  = glp_pkg::pow10(frac_k);
  assign scaled = 46'(acc_q) * 46'(scale);
  assign mag    = (scaled > 46'(glp_pkg::MAG_CAP)) ? glp_pkg::MAG_CAP : scaled[31:0];

  always_comb begin
    if (fl_q.neg) begin
      value_o = signed'(32'd0 - mag);
    end else if (mag[31]) begin
      value_o = signed'(glp_pkg::POS_MAX);
    end else begin
      value_o = signed'(mag);
    end
  end

endmodule

[test/gcode_line_parser_test.sv]
`timescale 1ns / 1ps
// self-checking testbench of the g-code line parser top level
// depends on glp_pkg and gcode_line_parser; predicts every line result word on its own
module gcode_line_parser_test;

  localparam int unsigned TOKEN_CHARS     = 8;
  localparam int unsigned FRACTION_DIGITS = 3;
  localparam int unsigned RANDOM_WORDS    = 1000;
  localparam int unsigned CALM_WORDS      = 150;   // no idling for this many final words
  localparam int unsigned WATCHDOG_LIMIT  = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;

  // parse flag bit positions of one coordinate
  localparam int FL_NEG   = 0;
  localparam int FL_POINT = 1;
  localparam int FL_STOP  = 2;
  localparam int FL_NOSGN = 3;

  // accumulator and flags of one coordinate conversion
  typedef struct packed {
    logic [31:0] acc;
    logic [6:0]  fl;     // bits 6..4 count the fraction digits taken
  } conv_t;

  // one expected line result word
  typedef struct {
    glp_pkg::cmd_e      cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [63:0]        pen;
    logic [3:0]         plen;
  } line_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_byte_i = 8'd0;
  logic               line_end_i  = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         command_code_o;
  logic signed [31:0] x_thousandths_o;
  logic signed [31:0] y_thousandths_o;
  logic [63:0]        pen_chars_o;
  logic [3:0]         pen_length_o;

  gcode_line_parser #(
    .TOKEN_CHARS    (TOKEN_CHARS),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_byte_i    (char_byte_i),
    .line_end_i     (line_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_code_o (command_code_o),
    .x_thousandths_o(x_thousandths_o),
    .y_thousandths_o(y_thousandths_o),
    .pen_chars_o    (pen_chars_o),
    .pen_length_o   (pen_length_o)
  );

  always #6 clk_i = ~clk_i;

  // parser copy: line state
  logic [2:0]  tok_no;
  logic [3:0]  char_pos;
  logic [23:0] kw;
  logic        kw_long;
  logic [63:0] tok2;
  logic [3:0]  tok2_len;
  conv_t       x_conv;
  conv_t       y_conv;
  // parser copy: values held across lines
  logic [31:0] held_x;
  logic [31:0] held_y;
  logic [63:0] held_pen;
  logic [3:0]  held_plen;

  line_result_t expected_lines[$];

  bit          gaps_on = 1'b1;
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned lines_sent = 0;
  int unsigned lines_checked = 0;
  int unsigned rx_hold = 0;
  int unsigned quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  task automatic clear_line();
    tok_no   = 3'd0;
    char_pos = 4'd0;
    kw       = 24'd0;
    kw_long  = 1'b0;
    tok2     = 64'd0;
    tok2_len = 4'd0;
    x_conv   = '0;
    y_conv   = '0;
  endtask

  // one character into a coordinate conversion
  function automatic conv_t conv_char(conv_t s, logic [7:0] c);
    conv_t       r;
    logic [2:0]  f;
    logic        take;
    logic [63:0] t;
    r = s;
    f = s.fl[6:4];
    if (r.fl[FL_STOP]) return r;
    // leading whitespace is skipped until a sign, digit or point shows up
    if (!r.fl[FL_NOSGN] && (c == glp_pkg::CHAR_TAB || c == glp_pkg::CHAR_VT ||
                            c == glp_pkg::CHAR_FF  || c == glp_pkg::CHAR_CR))
      return r;
    if (!r.fl[FL_NOSGN] && (c == glp_pkg::CHAR_PLUS || c == glp_pkg::CHAR_MINUS)) begin
      if (c == glp_pkg::CHAR_MINUS) r.fl[FL_NEG] = 1'b1;
      r.fl[FL_NOSGN] = 1'b1;
      return r;
    end
    if (c >= glp_pkg::CHAR_ZERO && c <= glp_pkg::CHAR_NINE) begin
      take = 1'b1;
      r.fl[FL_NOSGN] = 1'b1;
      if (r.fl[FL_POINT]) begin
        // decimals past the kept count are truncated
        if (f < FRACTION_DIGITS) r.fl[6:4] = f + 3'd1;
        else take = 1'b0;
      end
      if (take && r.acc < glp_pkg::MAG_CAP) begin
        t = 64'(r.acc) * 64'd10 + 64'(c - glp_pkg::CHAR_ZERO);
        r.acc = (t > 64'(glp_pkg::MAG_CAP)) ? glp_pkg::MAG_CAP : t[31:0];
      end
      return r;
    end
    if (c == glp_pkg::CHAR_POINT && !r.fl[FL_POINT]) begin
      r.fl[FL_POINT] = 1'b1;
      r.fl[FL_NOSGN] = 1'b1;
      return r;
    end
    r.fl[FL_STOP] = 1'b1;
    return r;
  endfunction

  // scale to thousandths, apply the sign and saturate
  function automatic logic [31:0] conv_final(conv_t s);
    logic [2:0]  f;
    int unsigned k;
    logic [63:0] scale;
    logic [63:0] v;
    f = s.fl[6:4];
    k = (f <= FRACTION_DIGITS) ? FRACTION_DIGITS - f : 0;
    scale = 64'd1;
    repeat (k) scale = scale * 64'd10;
    v = 64'(s.acc) * scale;
    if (v > 64'(glp_pkg::MAG_CAP)) v = 64'(glp_pkg::MAG_CAP);
    if (s.fl[FL_NEG]) return ~v[31:0] + 32'd1;
    if (v > 64'(glp_pkg::POS_MAX)) v = 64'(glp_pkg::POS_MAX);
    return v[31:0];
  endfunction

  // advance the parser copy by one accepted input word
  task automatic model_word(logic [7:0] c, logic le);
    line_result_t  res;
    glp_pkg::cmd_e code;
    if (!le) begin
      if (c == glp_pkg::CHAR_NUL) return;   // nul has no effect at all
      if (c == glp_pkg::CHAR_NL || c == glp_pkg::CHAR_SP) begin
        if (tok_no < 3'd7) tok_no = tok_no + 3'd1;
        char_pos = 4'd0;
        return;
      end
      case (tok_no)
        3'd0: begin
          if (char_pos < 4'd3) kw[8*char_pos +: 8] = c;
          else kw_long = 1'b1;
        end
        3'd1: begin
          if (char_pos < TOKEN_CHARS) begin
            tok2[8*char_pos +: 8] = c;
            tok2_len = char_pos + 4'd1;
          end
          // first character is the axis letter
          if (char_pos > 4'd0) x_conv = conv_char(x_conv, c);
        end
        3'd2: begin
          if (char_pos > 4'd0) y_conv = conv_char(y_conv, c);
        end
        default: ;
      endcase
      if (char_pos < 4'd15) char_pos = char_pos + 4'd1;
      return;
    end
    code = glp_pkg::CMD_CLEAR;
    if (!kw_long) begin
      if (kw == glp_pkg::KW_M10) begin
        code = glp_pkg::CMD_INIT;
      end else if (kw == glp_pkg::KW_M1) begin
        code = glp_pkg::CMD_SERVO;
        held_pen  = tok2;
        held_plen = tok2_len;
      end else if (kw == glp_pkg::KW_G1) begin
        code = glp_pkg::CMD_MOVE;
        held_x = conv_final(x_conv);
        held_y = conv_final(y_conv);
      end else if (kw == glp_pkg::KW_G28) begin
        code = glp_pkg::CMD_HOME;
      end
    end
    res.cmd  = code;
    res.x    = held_x;
    res.y    = held_y;
    res.pen  = held_pen;
    res.plen = held_plen;
    expected_lines.push_back(res);
    clear_line();
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic check_line_result();
    line_result_t exp_line;
    if (expected_lines.size() == 0) begin
      $error("result word with no line pending: command_code %0d", command_code_o);
      fail_count++;
      return;
    end
    exp_line = expected_lines.pop_front();
    lines_checked++;
    if (command_code_o !== exp_line.cmd) begin
      $error("command_code: expected %0d, actual %0d", exp_line.cmd, command_code_o);
      fail_count++;
    end
    if (x_thousandths_o !== exp_line.x) begin
      $error("x_thousandths: expected %0d, actual %0d", exp_line.x, x_thousandths_o);
      fail_count++;
    end
    if (y_thousandths_o !== exp_line.y) begin
      $error("y_thousandths: expected %0d, actual %0d", exp_line.y, y_thousandths_o);
      fail_count++;
    end
    if (pen_chars_o !== exp_line.pen) begin
      $error("pen_chars: expected %h, actual %h", exp_line.pen, pen_chars_o);
      fail_count++;
    end
    if (pen_length_o !== exp_line.plen) begin
      $error("pen_length: expected %0d, actual %0d", exp_line.plen, pen_length_o);
      fail_count++;
    end
  endtask

  // prediction first, so a result in the same cycle already finds its line
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) model_word(char_byte_i, line_end_i);
    if (rst_ni && out_valid_o && !out_stall_i) check_line_result();
  end

  // receiver stalls in bursts of random length
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) out_stall_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      rx_hold     <= $urandom_range(1, 11);
    end
  end

  // watchdog on cycles in which neither channel moves a word
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // send one word, at times after a random idle gap, and hold it until accepted; valid stays high afterwards
  task automatic send_word(logic [7:0] c, logic le);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    line_end_i  <= le;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // the byte that goes with a line end is ignored, so it is random
  task automatic end_line();
    send_word(8'($urandom_range(0, 255)), 1'b1);
    lines_sent++;
  endtask

  task automatic send_line(string s);
    send_text(s);
    end_line();
  endtask

  // sender holds off until every pending line result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_lines.size() != 0);
  endtask

  task automatic send_separator();
    send_word(($urandom_range(0, 4) == 0) ? glp_pkg::CHAR_NL : glp_pkg::CHAR_SP, 1'b0);
  endtask

  // axis letter, or at times a random character, then a number of random shape
  task automatic send_random_coord(logic [7:0] axis);
    int unsigned r;
    if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(33, 126)), 1'b0);
    else send_word(axis, 1'b0);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 3))
          0: send_word(glp_pkg::CHAR_TAB, 1'b0);
          1: send_word(glp_pkg::CHAR_VT, 1'b0);
          2: send_word(glp_pkg::CHAR_FF, 1'b0);
          default: send_word(glp_pkg::CHAR_CR, 1'b0);
        endcase
      end
    end
    r = $urandom_range(0, 3);
    if (r == 0) send_word(glp_pkg::CHAR_PLUS, 1'b0);
    if (r == 1) send_word(glp_pkg::CHAR_MINUS, 1'b0);
    // long digit runs reach the saturation
    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 7))
      send_word(glp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    if ($urandom_range(0, 1)) begin
      send_word(glp_pkg::CHAR_POINT, 1'b0);
      repeat ($urandom_range(0, 5))
        send_word(glp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: send_text("e5");
        1: send_word(glp_pkg::CHAR_POINT, 1'b0);
        2: send_word(glp_pkg::CHAR_MINUS, 1'b0);
        default: send_word(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
  endtask

  task automatic test_keywords();
    send_line("M10");
    send_line("G28");
    send_line("G28 X1");       // trailing tokens do not matter
    send_line("M100");         // long keyword never matches
    send_line("g1 X1");        // match is case exact
    end_line();                // empty line
  endtask

  task automatic test_pen_text();
    send_line("M1 up");
    send_line("M1 ABCDEFGHIJ"); // only the first eight characters are kept
    send_line("M10");           // pen is held across other commands
    send_line("M1");            // absent pen text is empty
    send_text("M1 a");          // nul inside the token is dropped
    send_word(glp_pkg::CHAR_NUL, 1'b0);
    send_text("b");
    end_line();
    send_text("M1 ");           // top-bit bytes as pen text
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    end_line();
  endtask

  task automatic test_coordinates();
    send_line("G1 X12.5 Y-3.25");
    send_line("G1 X2147483.647 Y-2147483.648");
    send_line("G1 X2147483.648 Y-2147483.649"); // just past both limits
    send_line("G1 X99999999999 Y-99999999999");
    send_line("G1 X1.23456 Y+.5");              // extra decimals truncated
    send_line("G1 X\011-7 Yabc");               // whitespace before sign, letters stop
    send_line("G1 X1e5 Y0x10");                 // no exponent, no hex
    send_line("G1 X1..2 Y--3");                 // second point or sign stops
    send_line("G1 X+-1 Y\015\014\0139");        // carriage return, form feed, vertical tab
    send_line("G28");                           // point is held
    send_line("G1");                            // absent coordinates give zero
  endtask

  task automatic test_separators();
    send_line("G1  X5 Y6");                     // empty token shifts the others
    send_line("G1\nX1\nY2");                    // newline character separates tokens
    send_line("G1 X1 Y2 Z3 W4 A5 B6 C7 D8 E9"); // token count saturates
    send_line("G1 X000000000000000000012.5 Y7");
  endtask

  task automatic test_random_lines();
    int unsigned start_words;
    string       kw_text;
    int unsigned pos;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      if (words_sent - start_words >= RANDOM_WORDS - CALM_WORDS) gaps_on = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_text("G1");
          send_separator();
          send_random_coord("X");
          send_separator();
          send_random_coord("Y");
          if ($urandom_range(0, 5) == 0) begin
            send_separator();
            send_random_coord("Z");
          end
        end
        4, 5: begin
          send_text("M1");
          if ($urandom_range(0, 7) != 0) begin
            send_separator();
            repeat ($urandom_range(0, 11)) begin
              if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(1, 255)), 1'b0);
              else send_word(8'($urandom_range(33, 126)), 1'b0);
            end
          end
        end
        6: begin
          send_text($urandom_range(0, 1) ? "M10" : "G28");
          if ($urandom_range(0, 3) == 0) begin
            send_separator();
            send_random_coord("X");
          end
        end
        7: begin
          // raw noise, any byte value
          repeat ($urandom_range(0, 15)) send_word(8'($urandom_range(0, 255)), 1'b0);
        end
        8: begin
          // keyword that may have one character changed or one too many
          case ($urandom_range(0, 3))
            0: kw_text = "M10";
            1: kw_text = "M1";
            2: kw_text = "G1";
            default: kw_text = "G28";
          endcase
          pos = $urandom_range(0, kw_text.len() - 1);
          for (int i = 0; i < kw_text.len(); i++) begin
            if (i == pos && $urandom_range(0, 1)) send_word(8'($urandom_range(33, 126)), 1'b0);
            else send_word(kw_text[i], 1'b0);
          end
          if ($urandom_range(0, 1)) send_word(8'($urandom_range(33, 126)), 1'b0);
          send_separator();
          send_random_coord("X");
        end
        default: begin
          // move with runs of separators and extra tokens
          send_text("G1");
          repeat ($urandom_range(1, 3)) send_separator();
          send_random_coord("X");
          repeat ($urandom_range(1, 3)) send_separator();
          send_random_coord("Y");
          repeat ($urandom_range(0, 6)) begin
            send_separator();
            send_random_coord("Q");
          end
        end
      endcase
      end_line();
      if (gaps_on && $urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    clear_line();
    held_x    = 32'd0;
    held_y    = 32'd0;
    held_pen  = 64'd0;
    held_plen = 4'd0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_keywords();
    test_pen_text();
    wait_drained();
    test_coordinates();
    test_separators();
    wait_drained();
    test_random_lines();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("summary: %0d lines in %0d words, %0d result words checked", lines_sent,
             words_sent, lines_checked);
    $display("summary: all keywords, pen text, coordinate sign, point, truncation and clamp");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[gcode_line_parser.f]
+incdir+rtl/core
rtl/core/glp_pkg.sv
rtl/core/glp_num_conv.sv
rtl/core/gcode_line_parser.sv
test/gcode_line_parser_test.sv
